// ----- src/hng_pkg.sv -----
package hng_pkg;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RD1,
    F_EMIT
  } hng_fstate_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQ,
    B_SUM,
    B_ITER,
    B_DONE
  } hng_bstate_e;

  typedef struct packed {
    logic [15:0] row;
    logic [9:0]  col;
    logic        last;
  } hng_tag_t;

  localparam int TAG_W = $bits(hng_tag_t);

  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  localparam logic [10:0] COLS_RESET = 11'd1024;
  localparam logic [15:0] ROWS_RESET = 16'd1024;

  // z before normalising is 10 (height step of one tenth), squared here
  localparam int Z_SQ       = 100;
  localparam int FRAC_SHIFT = 30;
  localparam int QUEUE_DEPTH = 4;

endpackage

// ----- src/hng_fifo.sv -----
module hng_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         full_o,
  output logic         empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   slot_q [DEPTH];
  logic [AW-1:0]  wr_q, rd_q;
  logic [CNW-1:0] cnt_q;

  assign full_o  = (cnt_q == CNW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      if (pop_i)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CNW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CNW'(1);
    end
  end

endmodule

// ----- src/hng_front.sv -----
module hng_front
  import hng_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [10:0]                   cols_i,
  input  logic [15:0]                   rows_i,
  input  logic                          restart_i,
  input  logic                          smp_valid_i,
  input  logic signed [SAMPLE_BITS-1:0] smp_i,
  output logic                          smp_stall_o,
  output logic                          push_o,
  input  logic                          full_i,
  output logic signed [SAMPLE_BITS:0]   dc_o,
  output logic signed [SAMPLE_BITS:0]   dr_o,
  output hng_tag_t                      tag_o
);

  localparam int CIW = $clog2(MAX_COLUMNS);
  localparam int CW  = $clog2(MAX_COLUMNS + 1);
  localparam int EW  = (CW > 11) ? CW : 11;
  localparam int XW  = (CIW > 10) ? CIW : 10;
  localparam int DW  = SAMPLE_BITS + 1;

  hng_fstate_e state_q, state_d;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_COLUMNS];
  logic signed [SAMPLE_BITS-1:0] rd_q, smp_q, left_q, prev_q, up_q;
  logic [CIW-1:0] col_q, rd_addr;
  logic [15:0]    row_q;
  logic [1:0]     k_q;

  logic [EW-1:0] cols_ext, cols_eff;
  logic [15:0]   rows_eff;
  logic          last_col, last_row, accept, adv, commit;
  logic [2:0]    flag;
  logic          cur_flag, is_last;
  logic [XW-1:0] col_x, colm_x;

  logic signed [DW-1:0] s_x, up_x, upn_x, left_x, prev_x;

  assign cols_ext = EW'(cols_i);
  always_comb begin
    if (cols_ext < EW'(2))                cols_eff = EW'(2);
    else if (cols_ext > EW'(MAX_COLUMNS)) cols_eff = EW'(MAX_COLUMNS);
    else                                  cols_eff = cols_ext;
  end
  assign rows_eff = (rows_i < 16'd2) ? 16'd2 : rows_i;

  assign last_col = (EW'(col_q) + EW'(1)) >= cols_eff;
  assign last_row = ({1'b0, row_q} + 17'd1) >= {1'b0, rows_eff};

  // points owed: one row up, left neighbour in last row, self at end of last row
  assign flag[0] = (row_q != 16'd0);
  assign flag[1] = last_row && (col_q != '0);
  assign flag[2] = last_row && last_col;

  assign s_x    = DW'(smp_q);
  assign up_x   = DW'(up_q);
  assign upn_x  = DW'(rd_q);
  assign left_x = DW'(left_q);
  assign prev_x = DW'(prev_q);

  assign col_x  = XW'(col_q);
  assign colm_x = XW'(col_q - CIW'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (accept) state_d = F_RD1;
      F_RD1:  state_d = F_EMIT;
      F_EMIT: if (commit) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    smp_stall_o = (state_q != F_IDLE);
    accept      = smp_valid_i && !smp_stall_o;
    cur_flag    = flag[k_q];
    push_o      = (state_q == F_EMIT) && cur_flag && !full_i;
    adv         = (state_q == F_EMIT) && (!cur_flag || !full_i);
    commit      = adv && (k_q == 2'd2);
    rd_addr     = (state_q == F_IDLE || last_col) ? col_q : col_q + CIW'(1);
    case (k_q)
      2'd0:    is_last = !(flag[1] || flag[2]);
      2'd1:    is_last = !flag[2];
      default: is_last = 1'b1;
    endcase
    tag_o.last = is_last;
    case (k_q)
      2'd0: begin
        dc_o      = last_col ? (up_x - prev_x) : (upn_x - up_x);
        dr_o      = s_x - up_x;
        tag_o.row = row_q - 16'd1;
        tag_o.col = col_x[9:0];
      end
      2'd1: begin
        dc_o      = s_x - left_x;
        dr_o      = left_x - prev_x;
        tag_o.row = row_q;
        tag_o.col = colm_x[9:0];
      end
      default: begin
        dc_o      = s_x - left_x;
        dr_o      = s_x - up_x;
        tag_o.row = row_q;
        tag_o.col = col_x[9:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
    if (commit) begin
      mem[col_q] <= smp_q;
      left_q     <= smp_q;
      prev_q     <= up_q;
    end
    if (accept) smp_q <= smp_i;
    if (state_q == F_RD1) up_q <= rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_RD1) k_q <= '0;
      else if (adv && !commit) k_q <= k_q + 2'd1;
      if (restart_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (commit) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? 16'd0 : row_q + 16'd1;
        end else begin
          col_q <= col_q + CIW'(1);
        end
      end
    end
  end

endmodule

// ----- src/hng_qunit.sv -----
// Digit-by-digit round(16384*a/sqrt(s)): tests s*(2q-1)^2 <= a^2*2^30 per bit,
// keeping q*s and q^2*s as running sums so no multiplier is needed.
module hng_qunit #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic [2*SAMPLE_BITS-1:0]   a2_i,
  input  logic [2*SAMPLE_BITS+1:0]   s_i,
  input  logic                       step_i,
  output logic [14:0]                q_o
);

  localparam int LW = 2 * SAMPLE_BITS + 34;

  logic [14:0]   q_q, bit_q;
  logic [LW-1:0] qs_q, q2s_q, u_q, sb_q, s2b_q, s_q, r_q;
  logic [LW-1:0] cand_sq, cand_s, lhs;
  logic          ok;

  assign cand_sq = q2s_q + u_q + s2b_q;
  assign cand_s  = qs_q + sb_q;
  assign lhs     = (cand_sq << 2) + s_q - (cand_s << 2);
  assign ok      = (bit_q[14] || !q_q[14]) && (lhs <= r_q);
  assign q_o     = q_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      q_q   <= '0;
      bit_q <= 15'h4000;
      qs_q  <= '0;
      q2s_q <= '0;
      u_q   <= '0;
      s_q   <= LW'(s_i);
      sb_q  <= LW'(s_i) << 14;
      s2b_q <= LW'(s_i) << 28;
      r_q   <= LW'(a2_i) << hng_pkg::FRAC_SHIFT;
    end else if (step_i) begin
      if (ok) begin
        q_q   <= q_q | bit_q;
        qs_q  <= cand_s;
        q2s_q <= cand_sq;
      end
      u_q   <= (u_q >> 1) + (ok ? s2b_q : '0);
      sb_q  <= sb_q >> 1;
      s2b_q <= s2b_q >> 2;
      bit_q <= bit_q >> 1;
    end
  end

endmodule

// ----- src/hng_back.sv -----
module hng_back
  import hng_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  output logic                        pop_o,
  input  logic signed [SAMPLE_BITS:0] dc_i,
  input  logic signed [SAMPLE_BITS:0] dr_i,
  input  hng_tag_t                    tag_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [15:0]          normal_x_o,
  output logic signed [15:0]          normal_y_o,
  output logic [14:0]                 normal_z_o,
  output logic [15:0]                 point_row_o,
  output logic [9:0]                  point_column_o,
  output logic                        last_of_run_o
);

  localparam int SB = SAMPLE_BITS;

  hng_bstate_e state_q, state_d;

  logic [SB-1:0]     ax_q, ay_q;
  logic [2*SB-1:0]   ax2_q, ay2_q;
  logic [2*SB+1:0]   s_sum;
  logic              negx_q, negy_q;
  hng_tag_t          tag_q;
  logic [3:0]        cnt_q;
  logic [14:0]       qx, qy, qz;
  logic [SB:0]       mx, my;
  logic              load, step, out_free, deliver;

  assign mx    = dc_i[SB] ? -dc_i : dc_i;
  assign my    = dr_i[SB] ? -dr_i : dr_i;
  assign s_sum = {2'b0, ax2_q} + {2'b0, ay2_q} + (2*SB+2)'(Z_SQ);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (!empty_i) state_d = B_SQ;
      B_SQ:   state_d = B_SUM;
      B_SUM:  state_d = B_ITER;
      B_ITER: if (cnt_q == 4'd0) state_d = B_DONE;
      B_DONE: if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    out_free = !out_valid_o || !out_stall_i;
    pop_o    = (state_q == B_IDLE) && !empty_i;
    load     = (state_q == B_SUM);
    step     = (state_q == B_ITER);
    deliver  = (state_q == B_DONE) && out_free;
  end

  hng_qunit #(.SAMPLE_BITS(SB)) u_qx (
    .clk_i, .load_i(load), .a2_i(ax2_q), .s_i(s_sum), .step_i(step), .q_o(qx)
  );
  hng_qunit #(.SAMPLE_BITS(SB)) u_qy (
    .clk_i, .load_i(load), .a2_i(ay2_q), .s_i(s_sum), .step_i(step), .q_o(qy)
  );
  hng_qunit #(.SAMPLE_BITS(SB)) u_qz (
    .clk_i, .load_i(load), .a2_i((2*SB)'(Z_SQ)), .s_i(s_sum), .step_i(step), .q_o(qz)
  );

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ax_q   <= mx[SB-1:0];
      ay_q   <= my[SB-1:0];
      negx_q <= (dc_i > 0);   // x is -dc
      negy_q <= dr_i[SB];
      tag_q  <= tag_i;
    end
    if (state_q == B_SQ) begin
      ax2_q <= ax_q * ax_q;
      ay2_q <= ay_q * ay_q;
    end
    if (deliver) begin
      normal_x_o     <= negx_q ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      normal_y_o     <= negy_q ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      normal_z_o     <= qz;
      point_row_o    <= tag_q.row;
      point_column_o <= tag_q.col;
      last_of_run_o  <= tag_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) cnt_q <= 4'd14;
      else if (step) cnt_q <= cnt_q - 4'd1;
      if (deliver) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

endmodule

// ----- src/heightmap_normal_generator_unit.sv -----
// Heightmap normal generator: height samples go in raster order, one word per
// accept, and each grid point yields a unit normal (Q1.14) once its right and
// lower neighbours are in. The front end accepts a word, reads the line buffer,
// then steps through the three possible normals, owed or not, holding while the
// queue is full; it takes no new word until that is done. Each normal is then
// worked out in the back end by the 15-step bit-serial normalising units, one
// normal at a time. A 4-entry queue lets the front run ahead. A register write
// restarts the frame at row 0, column 0.
module heightmap_normal_generator_unit
  import hng_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] height_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [15:0]            normal_x_o,
  output logic signed [15:0]            normal_y_o,
  output logic [14:0]                   normal_z_o,
  output logic [15:0]                   point_row_o,
  output logic [9:0]                    point_column_o,
  output logic                          last_of_run_o
);

  localparam int DW = SAMPLE_BITS + 1;
  localparam int QW = TAG_W + 2 * DW;

  logic [10:0] cols_q;
  logic [15:0] rows_q;
  logic        wr;

  logic                 push, pop, full, empty;
  logic signed [DW-1:0] f_dc, f_dr;
  hng_tag_t             f_tag;
  logic [QW-1:0]        q_out;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_ROWS) ? {16'b0, rows_q} : {21'b0, cols_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
    end else if (wr) begin
      if (paddr[2] == REG_COLS) cols_q <= pwdata[10:0];
      else                      rows_q <= pwdata[15:0];
    end
  end

  hng_front #(.MAX_COLUMNS(MAX_COLUMNS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni,
    .cols_i(cols_q), .rows_i(rows_q), .restart_i(wr),
    .smp_valid_i(in_valid_i), .smp_i(height_sample_i), .smp_stall_o(in_stall_o),
    .push_o(push), .full_i(full), .dc_o(f_dc), .dr_o(f_dr), .tag_o(f_tag)
  );

  hng_fifo #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .data_i({f_tag, f_dc, f_dr}),
    .pop_i(pop), .data_o(q_out), .full_o(full), .empty_o(empty)
  );

  hng_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .pop_o(pop),
    .dc_i(q_out[2*DW-1:DW]), .dr_i(q_out[DW-1:0]), .tag_i(q_out[QW-1:2*DW]),
    .out_valid_o, .out_stall_i,
    .normal_x_o, .normal_y_o, .normal_z_o,
    .point_row_o, .point_column_o, .last_of_run_o
  );

endmodule

// ----- src/hng_checker.sv -----
module hng_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] normal_x_o,
  input logic signed [15:0] normal_y_o,
  input logic [14:0]        normal_z_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(normal_x_o)
      && $stable(normal_y_o) && $stable(normal_z_o))
    else $error("output word changed while stalled");

  a_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normal_z_o <= 15'd16384)
    else $error("normal z above one");

  a_xy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normal_x_o >= -16'sd16384 && normal_x_o <= 16'sd16384
      && normal_y_o >= -16'sd16384 && normal_y_o <= 16'sd16384)
    else $error("normal x or y outside unit range");

endmodule

bind heightmap_normal_generator_unit hng_checker u_hng_checker (.*);

// ----- tb/sv/tb_heightmap_normal_generator_unit.sv -----
module tb_heightmap_normal_generator_unit;
  import hng_pkg::*;

  typedef struct {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [14:0] nz;
    logic [15:0] row;
    logic [9:0]  col;
    logic        last;
  } normal_t;

  class normal_predictor;
    int unsigned cols_reg = 1024;
    int unsigned rows_reg = 1024;
    int unsigned col_cnt, row_cnt;
    int upper_row[1024];
    int cur_row[1024];
    int left_val;
    normal_t expected_normals[$];
    int errors;

    function void write_reg(bit idx, int unsigned val);
      if (idx == REG_COLS) cols_reg = val & 'h7ff;
      else rows_reg = val & 'hffff;
      col_cnt = 0;
      row_cnt = 0;
    endfunction

    // round(16384 * a / sqrt(s)), ties up, bit by bit as exact integers
    function logic [15:0] q14_mag(longint unsigned a, longint unsigned s);
      logic [15:0] q;
      logic [15:0] cand;
      bit [127:0] lhs, rhs, t;
      q = 0;
      t = a * 32768;
      rhs = t * t;
      for (int b = 14; b >= 0; b--) begin
        cand = q | (16'd1 << b);
        lhs = 2 * cand - 1;
        lhs = lhs * lhs * s;
        if (cand <= 16384 && lhs <= rhs) q = cand;
      end
      return q;
    endfunction

    function logic [15:0] q14_signed(longint v, longint unsigned s);
      logic [15:0] q;
      q = q14_mag(v < 0 ? -v : v, s);
      return v < 0 ? -q : q;
    endfunction

    function void push_normal(longint dc, longint dr, int unsigned r, int unsigned c);
      normal_t n;
      longint unsigned s;
      s = dc * dc + dr * dr + 100;
      n.nx = q14_signed(-dc, s);
      n.ny = q14_signed(dr, s);
      n.nz = q14_mag(10, s);
      n.row = r;
      n.col = c;
      n.last = 0;
      expected_normals.push_back(n);
    endfunction

    function void note_sample(logic signed [15:0] smp);
      int unsigned cols, rows, c, r, n0;
      int sv, up;
      longint dc;
      cols = cols_reg < 2 ? 2 : (cols_reg > 1024 ? 1024 : cols_reg);
      rows = rows_reg < 2 ? 2 : rows_reg;
      sv = smp;
      c = col_cnt >= cols ? cols - 1 : col_cnt;
      r = row_cnt;
      n0 = expected_normals.size();
      if (r >= 1) begin
        up = upper_row[c];
        dc = (c + 1 < cols) ? upper_row[c+1] - up : up - upper_row[c-1];
        push_normal(dc, sv - up, r - 1, c);
      end
      if (r + 1 >= rows) begin
        if (c >= 1) push_normal(sv - left_val, left_val - upper_row[c-1], r, c - 1);
        if (c + 1 >= cols) push_normal(sv - left_val, sv - upper_row[c], r, c);
      end
      cur_row[c] = sv;
      left_val = sv;
      if (c + 1 >= cols) begin
        upper_row = cur_row;
        col_cnt = 0;
        row_cnt = (r + 1 >= rows) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
      if (expected_normals.size() > n0)
        expected_normals[expected_normals.size()-1].last = 1;
    endfunction

    function void cmp(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_normal(normal_t got);
      normal_t e;
      if (expected_normals.size() == 0) begin
        $display("%0t: unexpected normal, expected none, got row %0d col %0d",
                 $time, got.row, got.col);
        errors++;
        return;
      end
      e = expected_normals.pop_front();
      cmp("normal_x", e.nx, got.nx);
      cmp("normal_y", e.ny, got.ny);
      cmp("normal_z", e.nz, got.nz);
      cmp("point_row", e.row, got.row);
      cmp("point_column", e.col, got.col);
      cmp("last_of_run", e.last, got.last);
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic signed [15:0] height_sample_i = 0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic signed [15:0] normal_x_o, normal_y_o;
  logic [14:0] normal_z_o;
  logic [15:0] point_row_o;
  logic [9:0] point_column_o;
  logic last_of_run_o;

  normal_predictor pred = new();
  bit quiet_in, quiet_out;
  int stall_left;
  logic signed [15:0] prev_h;

  heightmap_normal_generator_unit dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  function automatic int gap_len(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_left = gap_len(quiet_out);
      out_stall_i = stall_left > 0;
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    normal_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.nx = normal_x_o;
      got.ny = normal_y_o;
      got.nz = normal_z_o;
      got.row = point_row_o;
      got.col = point_column_o;
      got.last = last_of_run_o;
      pred.check_normal(got);
    end
  end

  task automatic apb_write(bit idx, int unsigned val);
    @(negedge clk_i);
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = idx * 4;
    pwdata = val;
    @(negedge clk_i);
    penable = 1;
    do @(posedge clk_i); while (!pready);
    pred.write_reg(idx, val);
    @(negedge clk_i);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  // caller sits at a falling edge; returns at the falling edge after acceptance
  task automatic send_height(logic signed [15:0] h);
    int g;
    g = gap_len(quiet_in);
    if (g > 0) begin
      in_valid_i = 0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i = 1;
    height_sample_i = h;
    do @(posedge clk_i); while (in_stall_o);
    pred.note_sample(h);
    @(negedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 0;
    while (pred.expected_normals.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_height();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) prev_h = prev_h + $signed($urandom_range(0, 200)) - 100;
    else if (r < 88) prev_h = $urandom();
    else prev_h = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return prev_h;
  endfunction

  task automatic run_phase(int unsigned cols, int unsigned rows, int unsigned n);
    apb_write(REG_COLS, cols);
    apb_write(REG_ROWS, rows);
    quiet_in = $urandom_range(0, 3) == 0;
    quiet_out = $urandom_range(0, 3) == 0;
    @(negedge clk_i);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        quiet_in = !quiet_in;
        quiet_out = $urandom_range(0, 1);
      end
      send_height(pick_height());
    end
    drain();
  endtask

  initial begin
    logic signed [15:0] dir[8] = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                                   16'sh0000, 16'sh0000, 16'sh0001, 16'shffff};
    int unsigned c, r;
    prev_h = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // reset geometry: row 0 words only, nothing comes out
    for (int i = 0; i < 12; i++) send_height(i[0] ? 16'sh7fff : 16'sh8000);
    drain();
    // smallest grid, extreme steps in both directions, flat patch, then wrap
    apb_write(REG_COLS, 2);
    apb_write(REG_ROWS, 2);
    @(negedge clk_i);
    foreach (dir[i]) send_height(dir[i]);
    drain();
    run_phase(3, 2, 30);
    run_phase(0, 1, 24);           // both clamp up to 2
    run_phase(2047, 2, 20);        // clamps to the widest row
    run_phase(1024, 3, 20);
    run_phase(1, 65535, 40);       // deep frame, last row never reached
    run_phase(5, 0, 30);
    for (int p = 0; p < 8; p++) begin
      c = $urandom_range(2, 8);
      r = $urandom_range(2, 4);
      run_phase(c, r, c * r + $urandom_range(0, c));
    end
    if (pred.errors == 0 && pred.expected_normals.size() == 0)
      $display("heightmap_normal_generator_unit verification clean");
    else
      $display("heightmap_normal_generator_unit verification failed");
    $finish;
  end

  initial begin
    #200000000;
    $display("heightmap_normal_generator_unit verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
src/hng_pkg.sv
src/hng_fifo.sv
src/hng_front.sv
src/hng_qunit.sv
src/hng_back.sv
src/heightmap_normal_generator_unit.sv
src/hng_checker.sv
tb/sv/tb_heightmap_normal_generator_unit.sv
